// File: rtl/core/text_mode_console_writer_defines.svh
// Assertion macros for the console writer checks.
`ifndef TEXT_MODE_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_MODE_CONSOLE_WRITER_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define TMCW_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define TMCW_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/tmcw_pkg.sv
`timescale 1ns / 1ps
package tmcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELLS      = COLUMNS * ROWS;
  localparam int COPY_CELLS = COLUMNS * (ROWS - 1);
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int IDX_W      = 11;
  localparam int CHAR_W     = 8;
  localparam int CELL_W     = 16;

  localparam logic [CHAR_W-1:0] TEXT_ATTR  = 8'h07;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE    = 8'h0a;
  localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'h00;
  localparam logic [CELL_W-1:0] BLANK_CELL = {TEXT_ATTR, BLANK_CHAR};

  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic latch;
    logic exec;
    logic clear_step;
    logic sweep_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_scroll;
    logic sweep_last;
  } status_t;

endpackage

// File: rtl/core/tmcw_dp.sv
`timescale 1ns / 1ps
module tmcw_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  tmcw_pkg::cmd_t                 cmd,
  output tmcw_pkg::status_t              status,
  input  logic                           mode,
  input  logic [tmcw_pkg::CHAR_W-1:0]    char_code,
  input  logic [tmcw_pkg::IDX_W-1:0]     cell_index,
  output logic [tmcw_pkg::CHAR_W-1:0]    read_char,
  output logic [tmcw_pkg::CHAR_W-1:0]    read_attr,
  output logic [tmcw_pkg::COL_W-1:0]     cursor_col,
  output logic [tmcw_pkg::ROW_W-1:0]     cursor_row,
  output logic                           scrolled
);

  logic [tmcw_pkg::CELL_W-1:0] mem [tmcw_pkg::CELLS];
  logic [tmcw_pkg::CELL_W-1:0] rd_q;

  logic                         mode_q;
  logic [tmcw_pkg::CHAR_W-1:0]  code_q;
  logic [tmcw_pkg::IDX_W-1:0]   index_q;
  logic                         scroll_q;

  logic [tmcw_pkg::COL_W-1:0]   cur_col;
  logic [tmcw_pkg::ROW_W-1:0]   cur_row;
  logic [tmcw_pkg::ADDR_W-1:0]  sweep;
  logic                         wr_pending;
  logic [tmcw_pkg::ADDR_W-1:0]  wr_addr;
  logic                         wr_blank;

  logic                         last_row, last_col, is_nl, is_print, is_put, in_range;
  logic                         sweep_copy, sweep_last, wraps;
  logic [tmcw_pkg::ADDR_W-1:0]  cur_pos;

  logic                         mem_we, mem_re;
  logic [tmcw_pkg::ADDR_W-1:0]  mem_wa, mem_ra;
  logic [tmcw_pkg::CELL_W-1:0]  mem_wd;

  assign last_row   = (cur_row == tmcw_pkg::ROW_W'(tmcw_pkg::ROWS - 1));
  assign last_col   = (cur_col == tmcw_pkg::COL_W'(tmcw_pkg::COLUMNS - 1));
  assign is_put     = (mode_q == tmcw_pkg::MODE_PUT);
  assign is_nl      = (code_q == tmcw_pkg::NEWLINE);
  assign is_print   = (code_q != tmcw_pkg::NUL_CHAR) && !is_nl;
  assign wraps      = is_nl || (is_print && last_col);
  assign in_range   = (int'(index_q) < tmcw_pkg::CELLS);
  assign cur_pos    = tmcw_pkg::ADDR_W'(cur_row) * tmcw_pkg::ADDR_W'(tmcw_pkg::COLUMNS)
                    + tmcw_pkg::ADDR_W'(cur_col);
  assign sweep_copy = (int'(sweep) < tmcw_pkg::COPY_CELLS);
  assign sweep_last = (sweep == tmcw_pkg::ADDR_W'(tmcw_pkg::CELLS - 1));

  assign status.need_scroll = is_put && last_row && wraps;
  assign status.sweep_last  = sweep_last;

  // Write port: scroll write stage, clearing pass, or a printed character.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = sweep;
    mem_wd = '0;
    if (wr_pending) begin
      mem_we = 1'b1;
      mem_wa = wr_addr;
      mem_wd = wr_blank ? tmcw_pkg::BLANK_CELL : rd_q;
    end else if (cmd.clear_step) begin
      mem_we = 1'b1;
    end else if (cmd.exec && is_put && is_print) begin
      mem_we = 1'b1;
      mem_wa = cur_pos;
      mem_wd = {tmcw_pkg::TEXT_ATTR, code_q};
    end
  end

  // Read port: source row of the scroll copy, or the addressed cell.
  always_comb begin
    mem_re = 1'b0;
    mem_ra = sweep + tmcw_pkg::ADDR_W'(tmcw_pkg::COLUMNS);
    if (cmd.sweep_step && sweep_copy) begin
      mem_re = 1'b1;
    end else if (cmd.exec && !is_put && in_range) begin
      mem_re = 1'b1;
      mem_ra = tmcw_pkg::ADDR_W'(index_q);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col    <= '0;
      cur_row    <= '0;
      sweep      <= '0;
      wr_pending <= 1'b0;
    end else begin
      if (cmd.clear_step || cmd.sweep_step) begin
        sweep <= sweep_last ? '0 : sweep + 1'b1;
      end
      wr_pending <= cmd.sweep_step;
      if (cmd.exec && is_put) begin
        if (wraps) begin
          cur_col <= '0;
          // Hold the last row: the scroll makes room instead.
          if (!last_row) cur_row <= cur_row + 1'b1;
        end else if (is_print) begin
          cur_col <= cur_col + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr  <= sweep;
    wr_blank <= !sweep_copy;
    if (cmd.latch) begin
      mode_q  <= mode;
      code_q  <= char_code;
      index_q <= cell_index;
    end
    if (cmd.exec) scroll_q <= status.need_scroll;
    if (cmd.load_out) begin
      if (!is_put && in_range) begin
        read_char <= rd_q[tmcw_pkg::CHAR_W-1:0];
        read_attr <= rd_q[tmcw_pkg::CELL_W-1:tmcw_pkg::CHAR_W];
      end else begin
        read_char <= '0;
        read_attr <= '0;
      end
      cursor_col <= cur_col;
      cursor_row <= cur_row;
      scrolled   <= scroll_q;
    end
  end

endmodule

// File: rtl/core/tmcw_ctrl.sv
`timescale 1ns / 1ps
module tmcw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tmcw_pkg::status_t status,
  output tmcw_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_FINISH
  } state_t;

  state_t state;
  logic   slot_free;

  assign slot_free      = !out_valid || out_ready;
  assign cmd.latch      = in_valid && in_ready;
  assign cmd.exec       = (state == ST_EXEC);
  assign cmd.clear_step = (state == ST_CLEAR);
  assign cmd.sweep_step = (state == ST_SCROLL);
  assign cmd.load_out   = (state == ST_FINISH) && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      in_ready  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          if (status.sweep_last) begin
            state    <= ST_IDLE;
            in_ready <= 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            state    <= ST_EXEC;
            in_ready <= 1'b0;
          end
        end
        ST_EXEC: begin
          state <= status.need_scroll ? ST_SCROLL : ST_FINISH;
        end
        ST_SCROLL: begin
          if (status.sweep_last) state <= ST_FINISH;
        end
        ST_FINISH: begin
          // Wait for the output register to free up, then reopen the input.
          if (slot_free) begin
            state    <= ST_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= ST_CLEAR;
          in_ready <= 1'b0;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/text_mode_console_writer.sv
// Flow: an accepted item (a read, a null byte, a newline or a printed character)
// passes EXEC and FINISH before out_valid rises; an item that scrolls also passes
// SCROLL, which sweeps the two-port screen store one cell per cycle (copy 1920
// cells, blank 80) before the result. A new item is taken only once FINISH loads it.
// Reset: synchronous, active high; a clearing pass zeroes all 2000 cells, one
// per cycle, with in_ready low, then the cursor sits at column 0, row 0.
`timescale 1ns / 1ps
module text_mode_console_writer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        mode,
  input  logic [tmcw_pkg::CHAR_W-1:0] char_code,
  input  logic [tmcw_pkg::IDX_W-1:0]  cell_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tmcw_pkg::CHAR_W-1:0] read_char,
  output logic [tmcw_pkg::CHAR_W-1:0] read_attr,
  output logic [tmcw_pkg::COL_W-1:0]  cursor_col,
  output logic [tmcw_pkg::ROW_W-1:0]  cursor_row,
  output logic                        scrolled
);

  tmcw_pkg::cmd_t    cmd;
  tmcw_pkg::status_t status;

  tmcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tmcw_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .mode       (mode),
    .char_code  (char_code),
    .cell_index (cell_index),
    .read_char  (read_char),
    .read_attr  (read_attr),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .scrolled   (scrolled)
  );

endmodule

// File: rtl/core/tmcw_checker.sv
`timescale 1ns / 1ps
`include "text_mode_console_writer_defines.svh"
module tmcw_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        mode,
  input logic [tmcw_pkg::CHAR_W-1:0] char_code,
  input logic [tmcw_pkg::IDX_W-1:0]  cell_index,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tmcw_pkg::CHAR_W-1:0] read_char,
  input logic [tmcw_pkg::CHAR_W-1:0] read_attr,
  input logic [tmcw_pkg::COL_W-1:0]  cursor_col,
  input logic [tmcw_pkg::ROW_W-1:0]  cursor_row,
  input logic                        scrolled
);

  `TMCW_CHECK(a_cursor_range, out_valid |-> (int'(cursor_col) < tmcw_pkg::COLUMNS && int'(cursor_row) < tmcw_pkg::ROWS), "cursor out of range")
  `TMCW_CHECK(a_scroll_pos, (out_valid && scrolled) |-> (cursor_col == '0 && int'(cursor_row) == tmcw_pkg::ROWS - 1), "scroll left cursor off the last row start")
  `TMCW_CHECK(a_attr_value, out_valid |-> (read_attr == '0 || read_attr == tmcw_pkg::TEXT_ATTR), "unexpected attribute byte")
  `TMCW_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while one is in work")
  `TMCW_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(cursor_col) && $stable(read_char), "stalled result changed")

endmodule

bind text_mode_console_writer tmcw_checker u_tmcw_checker (.*);

// File: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import tmcw_pkg::*;

  localparam int IDLE_LIMIT   = 20000;
  localparam int RANDOM_ITEMS = 1950;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] rchar;
    logic [CHAR_W-1:0] rattr;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              scrolled;
  } console_result_t;

  // Shadow copy of the screen and cursor; predicts one result per item.
  class console_shadow;
    logic [CELL_W-1:0] cells [CELLS];
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    console_result_t   pending_results [$];
    int                mismatches;

    function void clear();
      for (int i = 0; i < CELLS; i++) cells[i] = '0;
      col = '0;
      row = '0;
      mismatches = 0;
    endfunction

    function bit advance_line();
      col = '0;
      if (int'(row) + 1 >= ROWS) begin
        for (int i = 0; i < COPY_CELLS; i++) cells[i] = cells[i + COLUMNS];
        for (int i = COPY_CELLS; i < CELLS; i++) cells[i] = BLANK_CELL;
        return 1'b1;
      end
      row = row + 1'b1;
      return 1'b0;
    endfunction

    function void apply_item(logic m, logic [CHAR_W-1:0] code, logic [IDX_W-1:0] idx);
      console_result_t r;
      r = '0;
      if (m == MODE_READ) begin
        if (int'(idx) < CELLS) begin
          r.rchar = cells[idx][CHAR_W-1:0];
          r.rattr = cells[idx][CELL_W-1:CHAR_W];
        end
      end else if (code == NEWLINE) begin
        r.scrolled = advance_line();
      end else if (code != NUL_CHAR) begin
        cells[int'(row) * COLUMNS + int'(col)] = {TEXT_ATTR, code};
        if (int'(col) + 1 >= COLUMNS) r.scrolled = advance_line();
        else col = col + 1'b1;
      end
      r.col = col;
      r.row = row;
      pending_results.push_back(r);
    endfunction

    function void compare_result(console_result_t got);
      console_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: %0t: unexpected result char %02h attr %02h col %0d row %0d scr %0b",
                   $time, got.rchar, got.rattr, got.col, got.row, got.scrolled);
        return;
      end
      want = pending_results.pop_front();
      if (got.rchar !== want.rchar || got.rattr !== want.rattr || got.col !== want.col ||
          got.row !== want.row || got.scrolled !== want.scrolled) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"ERROR: %0t: expected char %02h attr %02h col %0d row %0d scr %0b,",
                    " got %02h %02h %0d %0d %0b"},
                   $time, want.rchar, want.rattr, want.col, want.row, want.scrolled,
                   got.rchar, got.rattr, got.col, got.row, got.scrolled);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              mode = MODE_PUT;
  logic [CHAR_W-1:0] char_code = '0;
  logic [IDX_W-1:0]  cell_index = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CHAR_W-1:0] read_char;
  logic [CHAR_W-1:0] read_attr;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic              scrolled;

  console_shadow shadow;
  bit            steady;
  int            sent_items;
  int            idle_cycles;

  text_mode_console_writer u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .char_code  (char_code),
    .cell_index (cell_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_char  (read_char),
    .read_attr  (read_attr),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .scrolled   (scrolled)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap();
    return steady ? 0 : int'($urandom_range(0, 6));
  endfunction

  // Favor the rows just printed so scrolled and written cells get read back.
  function automatic logic [IDX_W-1:0] pick_read_index();
    int sel;
    int text_row;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      text_row = int'(shadow.row);
      if (text_row > 0 && $urandom_range(0, 1) == 1) text_row--;
      return IDX_W'(text_row * COLUMNS + int'($urandom_range(0, COLUMNS - 1)));
    end else if (sel < 85) begin
      return IDX_W'($urandom_range(0, CELLS - 1));
    end
    return IDX_W'($urandom_range(CELLS - 10, 2 ** IDX_W - 1));
  endfunction

  function automatic logic [CHAR_W-1:0] pick_put_char();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return NEWLINE;
    if (sel < 13) return NUL_CHAR;
    if (sel < 20) return CHAR_W'($urandom_range(0, 255));
    return CHAR_W'($urandom_range(32, 126));
  endfunction

  task automatic issue_item(input logic m, input logic [CHAR_W-1:0] code,
                            input logic [IDX_W-1:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    char_code  <= code;
    cell_index <= idx;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent_items++;
  endtask

  always @(posedge clk) begin : result_monitor
    console_result_t seen;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (in_valid && in_ready) shadow.apply_item(mode, char_code, cell_index);
      if (out_valid && out_ready) begin
        seen.rchar    = read_char;
        seen.rattr    = read_attr;
        seen.col      = cursor_col;
        seen.row      = cursor_row;
        seen.scrolled = scrolled;
        shadow.compare_result(seen);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ERROR: no handshake for %0d cycles", IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int stall;
    while (rst) @(negedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int burst;
    shadow = new();
    shadow.clear();
    steady = 1'b0;
    sent_items = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Cleared screen, edges of the index range, ignored fields.
    issue_item(MODE_READ, 8'h00, 11'd0);
    issue_item(MODE_READ, 8'hff, IDX_W'(CELLS - 1));
    issue_item(MODE_READ, 8'h00, IDX_W'(CELLS));
    issue_item(MODE_READ, NEWLINE, 11'h7ff);
    issue_item(MODE_PUT, NUL_CHAR, 11'h7ff);
    issue_item(MODE_PUT, 8'hff, 11'd0);
    issue_item(MODE_PUT, 8'h01, 11'h7ff);
    issue_item(MODE_PUT, 8'h80, 11'd0);
    issue_item(MODE_PUT, 8'h7f, 11'd0);
    issue_item(MODE_PUT, NEWLINE, 11'd0);
    issue_item(MODE_PUT, NEWLINE, 11'd0);
    issue_item(MODE_PUT, 8'h41, 11'd0);
    issue_item(MODE_PUT, NUL_CHAR, 11'd0);
    issue_item(MODE_READ, 8'h00, 11'd0);
    issue_item(MODE_READ, 8'h00, 11'd1);
    issue_item(MODE_READ, 8'h00, 11'd2);
    issue_item(MODE_READ, 8'h00, 11'd3);
    issue_item(MODE_READ, 8'h00, 11'd4);
    issue_item(MODE_READ, 8'h00, IDX_W'(2 * COLUMNS));
    issue_item(MODE_READ, 8'h00, IDX_W'(2 * COLUMNS + 1));

    while (sent_items < RANDOM_ITEMS) begin
      if (steady ? ($urandom_range(0, 49) == 0) : ($urandom_range(0, 199) == 0))
        steady = !steady;
      if ($urandom_range(0, 999) < 3) begin
        // Long line without newline: mostly forces a wrap at the row end.
        burst = int'($urandom_range(COLUMNS - 2, COLUMNS + 20));
        repeat (burst)
          issue_item(MODE_PUT, CHAR_W'($urandom_range(33, 126)),
                     IDX_W'($urandom_range(0, 2047)));
      end else if ($urandom_range(0, 99) < 45) begin
        issue_item(MODE_READ, CHAR_W'($urandom_range(0, 255)), pick_read_index());
      end else begin
        issue_item(MODE_PUT, pick_put_char(), IDX_W'($urandom_range(0, 2047)));
      end
    end
    in_valid <= 1'b0;

    while (shadow.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (shadow.pending_results.size() != 0)
      $display("ERROR: %0d results never arrived", shadow.pending_results.size());
    if (shadow.mismatches == 0 && shadow.pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/tmcw_pkg.sv
rtl/core/tmcw_dp.sv
rtl/core/tmcw_ctrl.sv
rtl/core/text_mode_console_writer.sv
rtl/core/tmcw_checker.sv
test/testbench.sv
